// ===== hw/rtl/nmea_chk_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Beat types, result codes, line phase and the hex digit decode shared by
// the checker core, its line datapath and its assertion checker.
// ----------------------------------------------------------------------------
package nmea_chk_pkg;

   localparam int TagWidth  = 48;
   localparam int TagChars  = 6;
   localparam int FillWidth = 3;
   localparam int CsrAddrW  = 4;
   localparam int CsrDataW  = 64;

   localparam logic [7:0] STAR_CHAR = 8'h2a;

   localparam logic [TagWidth-1:0] FIRST_TAG_RESET  = 48'h2447_5047_4741; // $GPGGA
   localparam logic [TagWidth-1:0] SECOND_TAG_RESET = 48'h2447_5052_4d43; // $GPRMC

   // register index, taken from paddr[3]
   localparam logic REG_FIRST_TAG  = 1'b0;
   localparam logic REG_SECOND_TAG = 1'b1;

   localparam logic [1:0] KIND_UNKNOWN    = 2'd0;
   localparam logic [1:0] KIND_FIRST_TAG  = 2'd1;
   localparam logic [1:0] KIND_SECOND_TAG = 2'd2;
   localparam logic [1:0] KIND_CSUM_ERR   = 2'd3;

   typedef enum logic [1:0] {
      PHASE_FIRST = 2'd0,
      PHASE_SUM   = 2'd1,
      PHASE_HEX   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] computed_sum;
      logic [7:0] received_sum;
   } rsp_type;

   // bit 4 set: not a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      d = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = {1'b0, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         d = {1'b0, c[3:0] + 4'd9};
      end
      return d;
   endfunction

endpackage

// ===== hw/rtl/nmea_chk_line.sv =====
// ----------------------------------------------------------------------------
// NMEA line datapath
// Per-line state: running XOR, hex sum after the star, tag window and tag
// flags. Gives the result for the current beat and clears at line end.
// ----------------------------------------------------------------------------
module nmea_chk_line (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  beat_en,
   input  nmea_chk_pkg::req_type                 req,
   input  logic [nmea_chk_pkg::TagWidth-1:0]     first_tag,
   input  logic [nmea_chk_pkg::TagWidth-1:0]     second_tag,
   output nmea_chk_pkg::rsp_type                 result
);
   import nmea_chk_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [7:0]              xor_ff, xor_in;
   logic [7:0]              hex_ff, hex_in;
   logic                    run_ff, run_in;
   logic [TagWidth-1:0]     win_ff, win_in;
   logic [FillWidth-1:0]    fill_ff, fill_in;
   logic                    seen1_ff, seen1_in;
   logic                    seen2_ff, seen2_in;
   logic [4:0]              digit;
   logic                    full;
   logic                    csum_ok;

   assign digit = hex_digit(req.char_in);

   always_comb begin
      phase_in = phase_ff;
      xor_in   = xor_ff;
      hex_in   = hex_ff;
      run_in   = run_ff;
      unique case (phase_ff)
         PHASE_FIRST: begin
            phase_in = PHASE_SUM;
         end
         PHASE_SUM: begin
            if (req.char_in == STAR_CHAR) begin
               phase_in = PHASE_HEX;
            end else begin
               xor_in = xor_ff ^ req.char_in;
            end
         end
         PHASE_HEX: begin
            if (run_ff) begin
               if (!digit[4]) begin
                  hex_in = {hex_ff[3:0], digit[3:0]};
               end else begin
                  run_in = 1'b0;
               end
            end
         end
         default: begin
            phase_in = PHASE_FIRST;
         end
      endcase
   end

   // tag window: newest character in the low byte
   always_comb begin
      win_in   = {win_ff[TagWidth-9:0], req.char_in};
      fill_in  = (fill_ff == FillWidth'(TagChars)) ? fill_ff : fill_ff + 1'b1;
      full     = (fill_in == FillWidth'(TagChars));
      seen1_in = seen1_ff | (full && (win_in == first_tag));
      seen2_in = seen2_ff | (full && (win_in == second_tag));
   end

   always_comb begin
      csum_ok             = (phase_in == PHASE_HEX) && (xor_in == hex_in);
      result.computed_sum = xor_in;
      result.received_sum = (phase_in == PHASE_HEX) ? hex_in : 8'h00;
      if (!csum_ok) begin
         result.kind = KIND_CSUM_ERR;
      end else if (seen1_in) begin
         result.kind = KIND_FIRST_TAG;
      end else if (seen2_in) begin
         result.kind = KIND_SECOND_TAG;
      end else begin
         result.kind = KIND_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (beat_en && req.line_end)) begin
         phase_ff <= PHASE_FIRST;
         xor_ff   <= '0;
         hex_ff   <= '0;
         run_ff   <= 1'b1;
         win_ff   <= '0;
         fill_ff  <= '0;
         seen1_ff <= 1'b0;
         seen2_ff <= 1'b0;
      end else if (beat_en) begin
         phase_ff <= phase_in;
         xor_ff   <= xor_in;
         hex_ff   <= hex_in;
         run_ff   <= run_in;
         win_ff   <= win_in;
         fill_ff  <= fill_in;
         seen1_ff <= seen1_in;
         seen2_ff <= seen2_in;
      end
   end

endmodule

// ===== hw/rtl/nmea_sentence_checker_core.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checker core
// Checks the XOR checksum of NMEA 0183 sentences and spots two tags.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one character a beat; line_end marks the line's last one.
//   The first character is skipped, the rest up to the first '*' are XORed,
//   hex digits after the star form the received sum.
//   rsp_* gives one result beat per line: kind (unknown, first tag, second
//   tag or checksum error) with both sums.
//   The APB port holds the two 48-bit tags at byte addresses 0 and 8.
// Timing:
//   One character a cycle. The result is registered and shows in the cycle
//   after the line's last character is taken.
//   While a result sits unaccepted and rsp_ready is low, req_ready drops;
//   otherwise characters are taken every cycle, including the cycle that
//   hands over a result.
// Reset:
//   Clears the line state and the result valid flag and restores the default
//   tags $GPGGA and $GPRMC.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  nmea_chk_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output nmea_chk_pkg::rsp_type                rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [nmea_chk_pkg::CsrAddrW-1:0]    paddr,
   input  logic [nmea_chk_pkg::CsrDataW-1:0]    pwdata,
   output logic [nmea_chk_pkg::CsrDataW-1:0]    prdata,
   output logic                                 pready
);
   import nmea_chk_pkg::*;

   logic [TagWidth-1:0] first_tag_ff;
   logic [TagWidth-1:0] second_tag_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff;
   rsp_type             line_result;
   logic                beat_en;
   logic                csr_wr;
   logic                reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[3];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_tag_ff  <= FIRST_TAG_RESET;
         second_tag_ff <= SECOND_TAG_RESET;
      end else if (csr_wr) begin
         unique case (reg_sel)
            REG_FIRST_TAG:  first_tag_ff  <= pwdata[TagWidth-1:0];
            REG_SECOND_TAG: second_tag_ff <= pwdata[TagWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_FIRST_TAG:  prdata = CsrDataW'(first_tag_ff);
         REG_SECOND_TAG: prdata = CsrDataW'(second_tag_ff);
         default:        prdata = '0;
      endcase
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign beat_en   = req_valid && req_ready;

   nmea_chk_line u_line (
      .clock      (clock),
      .reset      (reset),
      .beat_en    (beat_en),
      .req        (req_data),
      .first_tag  (first_tag_ff),
      .second_tag (second_tag_ff),
      .result     (line_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (beat_en && req_data.line_end) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (beat_en && req_data.line_end) begin
         rsp_ff <= line_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/nmea_chk_checker.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checker assertions
// Port-level checks on the result beat timing and content, bound to the core.
// ----------------------------------------------------------------------------
module nmea_chk_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input nmea_chk_pkg::req_type                req_data,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input nmea_chk_pkg::rsp_type                rsp_data
);
   import nmea_chk_pkg::*;

   // no result straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat directly after reset");

   // a result only follows a line's last character
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_data.line_end))
      else $error("result beat without a line end");

   // a taken line end always yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.line_end) |=> rsp_valid)
      else $error("line end taken but no result beat");

   // input stalls while an unaccepted result is held
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("character taken while result held");

   // any kind other than checksum error means the sums agree
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind != KIND_CSUM_ERR) |->
         (rsp_data.computed_sum == rsp_data.received_sum))
      else $error("tag kind reported with mismatching sums");

endmodule

bind nmea_sentence_checker_core nmea_chk_checker u_nmea_chk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence checker core testbench
// Streams character beats through the checker under random sender bursts
// and receiver stalls, predicts each line result in the bench and compares
// it field by field. The two tag registers are set to several values over
// the run, the extremes among them, and read back over the APB port.
// ----------------------------------------------------------------------------
module testbench;
   import nmea_chk_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_CHARS = 330;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                psel      = 1'b0;
   logic                penable   = 1'b0;
   logic                pwrite    = 1'b0;
   logic [CsrAddrW-1:0] paddr     = '0;
   logic [CsrDataW-1:0] pwdata    = '0;
   logic [CsrDataW-1:0] prdata;
   logic                pready;

   nmea_sentence_checker_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // bench copy of the tag registers
   logic [TagWidth-1:0] tag_first  = FIRST_TAG_RESET;
   logic [TagWidth-1:0] tag_second = SECOND_TAG_RESET;

   // line state of the checksum predictor
   logic [7:0]          ln_xor       = '0;
   phase_type           ln_phase     = PHASE_FIRST;
   logic [7:0]          ln_hex       = '0;
   logic                ln_hex_open  = 1'b1;
   logic [TagWidth-1:0] ln_window    = '0;
   int                  ln_fill      = 0;
   logic                ln_first_hit = 1'b0;
   logic                ln_second_hit = 1'b0;

   req_type pending_q[$];
   rsp_type line_sums_q[$];

   bit req_taken     = 1'b0;
   int fail_count    = 0;
   int chars_sent    = 0;
   int results_seen  = 0;
   int settings_seen = 0;
   int kind_hits[4]  = '{0, 0, 0, 0};
   int quiet_cycles  = 0;
   int hold_asked    = 0;

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
      if (nib < 4'd10) return 8'h30 + 8'(nib);
      return (lower ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
   endfunction

   // advances the line state by one character; returns 1 at line end
   function automatic bit line_step(input req_type beat, output rsp_type res);
      int d;
      res = '0;
      case (ln_phase)
         PHASE_FIRST: ln_phase = PHASE_SUM;
         PHASE_SUM: begin
            if (beat.char_in == STAR_CHAR) ln_phase = PHASE_HEX;
            else ln_xor = ln_xor ^ beat.char_in;
         end
         default: begin
            if (ln_hex_open) begin
               d = hex_nibble(beat.char_in);
               if (d >= 0) ln_hex = {ln_hex[3:0], 4'(d)};
               else ln_hex_open = 1'b0;
            end
         end
      endcase
      ln_window = {ln_window[TagWidth-9:0], beat.char_in};
      if (ln_fill < TagChars) ln_fill++;
      if (ln_fill >= TagChars) begin
         if (ln_window == tag_first) ln_first_hit = 1'b1;
         if (ln_window == tag_second) ln_second_hit = 1'b1;
      end
      if (!beat.line_end) return 1'b0;
      if (ln_phase != PHASE_HEX || ln_xor != ln_hex) res.kind = KIND_CSUM_ERR;
      else if (ln_first_hit) res.kind = KIND_FIRST_TAG;
      else if (ln_second_hit) res.kind = KIND_SECOND_TAG;
      else res.kind = KIND_UNKNOWN;
      res.computed_sum = ln_xor;
      res.received_sum = (ln_phase == PHASE_HEX) ? ln_hex : 8'h00;
      ln_xor        = '0;
      ln_phase      = PHASE_FIRST;
      ln_hex        = '0;
      ln_hex_open   = 1'b1;
      ln_window     = '0;
      ln_fill       = 0;
      ln_first_hit  = 1'b0;
      ln_second_hit = 1'b0;
      return 1'b1;
   endfunction

   // sender: bursts of beats with random gaps, valid held until taken
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            req_data  <= pending_q.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 48);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern changes every so often, plus long hold-offs
   int rx_mode      = 0;
   int rx_mode_left = 0;
   int hold_left    = 0;
   int hold_done    = 0;
   bit rx_toggle    = 1'b0;

   always @(negedge clock) begin
      if (hold_done != hold_asked) begin
         hold_done = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(20, 200);
         end else begin
            rx_mode_left--;
         end
         rx_toggle = ~rx_toggle;
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= rx_toggle;
         endcase
      end
   end

   // result checking and prediction of accepted beats
   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type pred;
      req_taken = !reset && req_valid && req_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (line_sums_q.size() == 0) begin
            $error("result beat with nothing expected: kind %0d computed %02h received %02h",
                   rsp_data.kind, rsp_data.computed_sum, rsp_data.received_sum);
            fail_count++;
         end else begin
            want = line_sums_q.pop_front();
            kind_hits[rsp_data.kind]++;
            if (rsp_data.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_data.kind);
               fail_count++;
            end
            if (rsp_data.computed_sum !== want.computed_sum) begin
               $error("computed_sum: expected %02h, got %02h", want.computed_sum,
                      rsp_data.computed_sum);
               fail_count++;
            end
            if (rsp_data.received_sum !== want.received_sum) begin
               $error("received_sum: expected %02h, got %02h", want.received_sum,
                      rsp_data.received_sum);
               fail_count++;
            end
         end
      end
      if (req_taken) begin
         chars_sent++;
         if (line_step(req_data, pred)) line_sums_q.push_back(pred);
      end
   end

   // watchdog on cycles with no beat moving anywhere
   always @(posedge clock) begin
      if (reset || req_taken || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic push_line(input logic [7:0] text[$]);
      req_type beat;
      for (int i = 0; i < text.size(); i++) begin
         beat.char_in  = text[i];
         beat.line_end = (i == text.size() - 1);
         pending_q.push_back(beat);
      end
   endtask

   task automatic push_str(input string s);
      logic [7:0] text[$];
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      push_line(text);
   endtask

   task automatic check_tag(input logic idx);
      logic [TagWidth-1:0] want;
      want = (idx == REG_FIRST_TAG) ? tag_first : tag_second;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 3'b000};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {{(CsrDataW-TagWidth){1'b0}}, want}) begin
         $error("tag %0d readback: expected %012h, got %016h", idx, want, prdata);
         fail_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_tag(input logic idx, input logic [TagWidth-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= {{(CsrDataW-TagWidth){1'b0}}, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_FIRST_TAG) tag_first = value;
      else tag_second = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      check_tag(idx);
   endtask

   // mostly well-formed sentences with random content, the rest raw noise
   task automatic add_random_lines(input int budget);
      logic [7:0]          text[$];
      logic [7:0]          sum;
      logic [7:0]          c;
      logic [TagWidth-1:0] tag;
      int                  added;
      int                  pick;
      int                  n;
      added = 0;
      while (added < budget) begin
         text.delete();
         if ($urandom_range(0, 99) < 25) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) begin
               text.push_back(($urandom_range(0, 5) == 0) ? STAR_CHAR : 8'($urandom));
            end
         end else begin
            // tag part way into the line now and then
            if ($urandom_range(0, 3) == 0) begin
               n = $urandom_range(1, 3);
               for (int i = 0; i < n; i++) text.push_back(8'($urandom_range('h20, 'h7e)));
            end
            pick = $urandom_range(0, 4);
            case (pick)
               0: tag = tag_first;
               1: tag = tag_second;
               2: tag = {16'($urandom), 32'($urandom)};
               3: tag = {8'h24, 8'h47, 8'h50, 24'($urandom)};
               default: tag = tag_second;
            endcase
            for (int i = TagChars - 1; i >= 0; i--) text.push_back(tag[8*i +: 8]);
            if (pick == 4) begin
               // both tags in one line
               for (int i = TagChars - 1; i >= 0; i--) text.push_back(tag_first[8*i +: 8]);
            end
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++) begin
               c = 8'($urandom_range('h20, 'h7e));
               text.push_back((c == STAR_CHAR) ? 8'h2c : c);
            end
            sum = '0;
            for (int i = 1; i < text.size(); i++) sum ^= text[i];
            text.push_back(STAR_CHAR);
            if ($urandom_range(0, 9) == 0) sum ^= 8'($urandom_range(1, 255));
            if ($urandom_range(0, 9) != 0) begin
               if ($urandom_range(0, 7) == 0) begin
                  n = $urandom_range(1, 4);
                  for (int i = 0; i < n; i++) begin
                     text.push_back(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
                  end
               end
               text.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
               text.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
            end
            if ($urandom_range(0, 2) == 0) begin
               n = $urandom_range(1, 3);
               for (int i = 0; i < n; i++) begin
                  text.push_back(($urandom_range(0, 1) == 0) ? 8'h0d : 8'($urandom));
               end
            end
         end
         push_line(text);
         added += text.size();
      end
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid || line_sums_q.size() != 0) begin
         @(posedge clock);
      end
      // a beat may still sit in the result register
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_tag(REG_FIRST_TAG);
      check_tag(REG_SECOND_TAG);
      settings_seen++;

      // one-character line, zero byte
      push_line('{8'h00});
      // star as first character, then a star with no hex digits
      push_str("**");
      push_line('{8'hff, 8'hff});
      push_str("$GPGGA*56");
      // long lower-case hex run ended by a later star
      push_str("xA*f41*9");
      add_random_lines(PHASE_CHARS);
      wait_drained();

      set_tag(REG_FIRST_TAG, '0);
      set_tag(REG_SECOND_TAG, '1);
      settings_seen++;
      hold_asked++;
      add_random_lines(PHASE_CHARS);
      wait_drained();

      // equal tags: first tag wins
      set_tag(REG_FIRST_TAG, 48'h2447_4e47_4741);
      set_tag(REG_SECOND_TAG, 48'h2447_4e47_4741);
      settings_seen++;
      add_random_lines(PHASE_CHARS);
      wait_drained();

      set_tag(REG_FIRST_TAG, {16'($urandom), 32'($urandom)});
      set_tag(REG_SECOND_TAG, {16'($urandom), 32'($urandom)});
      settings_seen++;
      hold_asked++;
      add_random_lines(PHASE_CHARS);
      wait_drained();

      set_tag(REG_FIRST_TAG, FIRST_TAG_RESET);
      set_tag(REG_SECOND_TAG, SECOND_TAG_RESET);
      settings_seen++;
      add_random_lines(PHASE_CHARS);
      wait_drained();

      if (line_sums_q.size() != 0) begin
         $error("%0d line results never arrived", line_sums_q.size());
         fail_count++;
      end
      $display("sent %0d characters, checked %0d line results over %0d tag settings",
               chars_sent, results_seen, settings_seen);
      $display("line kinds: unknown %0d, first tag %0d, second tag %0d, checksum error %0d",
               kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3]);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
